/* design/pvr_pkg.sv */
// ----------------------------------------------------------------------------
// pvr_pkg: shared definitions for the PCM volume ramp block
// Field widths, register indexes, sample format codes, format constants and reset values.
// ----------------------------------------------------------------------------
package pvr_pkg;

  localparam int SAMPLE_W = 32;
  localparam int FMT_W    = 2;
  localparam int CHCNT_W  = 5;
  localparam int FRAME_W  = 20;
  localparam int VOL_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int BYTE_BITS = 8;
  localparam logic [BYTE_BITS-1:0] U8_OFFSET = 8'h80;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_START     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_END       = 3'd4;

  // sample format codes
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S24 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd3;

  // register reset values
  localparam logic [FMT_W-1:0]   RST_SAMPLE_FORMAT = FMT_S16;
  localparam logic [CHCNT_W-1:0] RST_CHANNEL_COUNT = 5'd2;
  localparam logic [FRAME_W-1:0] RST_FRAME_COUNT   = 20'd1024;
  localparam logic [VOL_W-1:0]   RST_VOL           = 17'd65536;

endpackage

/* design/pcm_volume_ramp_gain_top.sv */
// ----------------------------------------------------------------------------
// pcm_volume_ramp_gain_top: linear gain ramp with saturation for PCM buffers
// Scales interleaved samples by a gain that ramps from vol_start to vol_end
// across the frames of a buffer, saturates to the format, flags the last item.
// ----------------------------------------------------------------------------
// An item runs through the ramp multiply, divide, gain, sample multiply, round
// and finish states before out_valid; the ramp multiply and divide are skipped
// when the ramp is flat or the buffer has one frame.
// A new item is taken only in idle, after the ramp multiplier (20 steps), the
// restoring divider (37 steps), sample multiplier and any output stall are done.
// Reset (rst, synchronous): registers take their reset values, counters clear.
module pcm_volume_ramp_gain_top #(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int MAX_CHANNELS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pvr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pvr_pkg::SAMPLE_W-1:0]   sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pvr_pkg::SAMPLE_W-1:0]   sample_out,
  output logic                           buffer_last
);
  import pvr_pkg::*;

  // gain and product widths
  localparam int GW    = GAIN_FRAC_BITS + 1;          // gain 0 .. unity
  localparam int KW    = FRAME_W;                     // frame index
  localparam int PW    = VOL_W + KW;                  // |diff| * k
  localparam int GSW   = PW + 3;                      // signed gain sum
  localparam int SPW   = SAMPLE_W + GW;               // |s| * g
  localparam int RMW   = SAMPLE_W + 2;                // scaled magnitude
  localparam int RW    = SAMPLE_W + 3;                // signed scaled sample
  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNTW  = $clog2(PW + 1);
  localparam int UNITY_I    = 1 << GAIN_FRAC_BITS;
  localparam int GAIN_RST_I = (65536 > UNITY_I) ? UNITY_I : 65536;
  localparam logic [GW-1:0] UNITY    = GW'(UNITY_I);
  localparam logic [GW-1:0] GAIN_RST = GW'(GAIN_RST_I);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULK,
    ST_DIV,
    ST_GAIN,
    ST_MULS,
    ST_ROUND,
    ST_FIN
  } state_t;

  // configuration registers
  logic [FMT_W-1:0]   sample_format;
  logic [CHCNT_W-1:0] channel_count;
  logic [FRAME_W-1:0] frame_count;
  logic [VOL_W-1:0]   vol_start;
  logic [VOL_W-1:0]   vol_end;

  // buffer position
  logic [CW-1:0]      channel_position;
  logic [FRAME_W-1:0] frame_position;

  // datapath
  state_t             state;
  logic [CNTW-1:0]    step;
  logic [PW-1:0]      acc;          // ramp product, then dividend/quotient
  logic [FRAME_W-1:0] rem;
  logic [VOL_W-1:0]   dmag;
  logic               dneg;
  logic [SAMPLE_W-1:0] smag;
  logic               sneg;
  logic [GW-1:0]      ramp_gain;    // shifts out LSB first while scaling
  logic [SPW-1:0]     sacc;
  logic signed [RW-1:0] rval;
  logic               last_flag;

  // combinational helpers
  logic [FRAME_W-1:0]  divisor;
  logic signed [VOL_W:0] diff;
  logic                flat;
  logic [SAMPLE_W:0]   sval;
  logic [SAMPLE_W:0]   sneg_val;
  logic [5:0]          chans_m1;
  logic                last_ch;
  logic                last_fr;
  logic [VOL_W:0]      mk_sum;
  logic [FRAME_W:0]    trial;
  logic                div_ge;
  logic [PW:0]         qm;
  logic signed [GSW-1:0] gsum;
  logic [GW-1:0]       gclamp;
  logic [SAMPLE_W:0]   ms_sum;
  logic [SPW:0]        rnd_sum;
  logic [RMW-1:0]      rmag;
  logic signed [RW-1:0] sat_hi;
  logic signed [RW-1:0] sat_lo;
  logic signed [RW-1:0] sat;
  logic [SAMPLE_W-1:0] packed_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    // ramp divisor is frames-1, zero for a single-frame buffer
    divisor = (frame_count == '0) ? '0 : frame_count - 1'b1;
    diff    = $signed({1'b0, vol_end}) - $signed({1'b0, vol_start});
    flat    = (divisor == '0) || (diff == '0);

    // decode the raw sample to a signed value
    case (sample_format)
      FMT_U8:  sval = {{(SAMPLE_W + 1 - BYTE_BITS){1'b0}}, sample_in[BYTE_BITS-1:0]}
                      - {{(SAMPLE_W + 1 - BYTE_BITS){1'b0}}, U8_OFFSET};
      FMT_S16: sval = {{17{sample_in[15]}}, sample_in[15:0]};
      FMT_S24: sval = {{9{sample_in[23]}}, sample_in[23:0]};
      default: sval = {sample_in[SAMPLE_W-1], sample_in};
    endcase
    sneg_val = -sval;

    // last channel / last frame; out-of-range counts clamp to the limits
    if (channel_count == '0) begin
      chans_m1 = '0;
    end else if ({1'b0, channel_count} > 6'(MAX_CHANNELS)) begin
      chans_m1 = 6'(MAX_CHANNELS - 1);
    end else begin
      chans_m1 = {1'b0, channel_count} - 6'd1;
    end
    last_ch = {{(6 - CW){1'b0}}, channel_position} >= chans_m1;
    last_fr = frame_position >= divisor;

    // ramp multiply step: add |diff| when the low bit of k is set
    mk_sum = {1'b0, acc[PW-1:KW]} + (acc[0] ? {1'b0, dmag} : '0);

    // restoring divide step
    trial  = {rem, acc[PW-1]};
    div_ge = trial >= {1'b0, divisor};

    // floor toward minus infinity: bump the quotient magnitude on a remainder
    qm   = {1'b0, acc} + (PW + 1)'(dneg && (rem != '0));
    gsum = $signed({{(GSW - VOL_W){1'b0}}, vol_start})
           + (dneg ? -$signed({2'b00, qm}) : $signed({2'b00, qm}));
    if (gsum < 0) begin
      gclamp = '0;
    end else if (gsum > $signed({{(GSW - GW){1'b0}}, UNITY})) begin
      gclamp = UNITY;
    end else begin
      gclamp = gsum[GW-1:0];
    end

    // sample multiply step
    ms_sum = {1'b0, sacc[SPW-1:GW]} + (ramp_gain[0] ? {1'b0, smag} : '0);

    // scale down with floor
    rnd_sum = {1'b0, sacc} + (SPW + 1)'(UNITY_I - 1);
    rmag    = sneg ? rnd_sum[SPW:GAIN_FRAC_BITS] : {1'b0, sacc[SPW-1:GAIN_FRAC_BITS]};

    // saturate to the format's range and pack
    case (sample_format)
      FMT_U8: begin
        sat_hi = RW'(127);
        sat_lo = -RW'(128);
      end
      FMT_S16: begin
        sat_hi = RW'(32767);
        sat_lo = -RW'(32768);
      end
      FMT_S24: begin
        sat_hi = RW'(8388607);
        sat_lo = -RW'(8388608);
      end
      default: begin
        sat_hi = {{(RW - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
        sat_lo = {{(RW - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};
      end
    endcase
    if (rval > sat_hi) begin
      sat = sat_hi;
    end else if (rval < sat_lo) begin
      sat = sat_lo;
    end else begin
      sat = rval;
    end
    case (sample_format)
      FMT_U8:  packed_out = {{(SAMPLE_W - BYTE_BITS){1'b0}}, sat[BYTE_BITS-1:0] + U8_OFFSET};
      FMT_S16: packed_out = {16'd0, sat[15:0]};
      FMT_S24: packed_out = {8'd0, sat[23:0]};
      default: packed_out = sat[SAMPLE_W-1:0];
    endcase
  end

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= RST_SAMPLE_FORMAT;
      channel_count <= RST_CHANNEL_COUNT;
      frame_count   <= RST_FRAME_COUNT;
      vol_start     <= RST_VOL;
      vol_end       <= RST_VOL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_FORMAT: sample_format <= cfg_data[FMT_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHCNT_W-1:0];
        REG_FRAME_COUNT:   frame_count   <= cfg_data[FRAME_W-1:0];
        REG_VOL_START:     vol_start     <= cfg_data[VOL_W-1:0];
        REG_VOL_END:       vol_end       <= cfg_data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      step             <= '0;
      channel_position <= '0;
      frame_position   <= '0;
      ramp_gain        <= GAIN_RST;
      out_valid        <= 1'b0;
    end else begin
      // drop the result once it is taken; the final state loads the next one
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            // latch operands and advance the buffer position
            sneg      <= sval[SAMPLE_W];
            smag      <= sval[SAMPLE_W] ? sneg_val[SAMPLE_W-1:0] : sval[SAMPLE_W-1:0];
            dneg      <= diff[VOL_W];
            dmag      <= diff[VOL_W] ? VOL_W'(-diff) : diff[VOL_W-1:0];
            last_flag <= last_ch && last_fr;
            rem       <= '0;
            step      <= '0;
            if (flat) begin
              acc   <= '0;
              state <= ST_GAIN;
            end else begin
              acc   <= {{VOL_W{1'b0}}, frame_position};
              state <= ST_MULK;
            end
            if (last_ch && last_fr) begin
              channel_position <= '0;
              frame_position   <= '0;
            end else if (last_ch) begin
              channel_position <= '0;
              frame_position   <= frame_position + 1'b1;
            end else begin
              channel_position <= channel_position + 1'b1;
            end
          end
        end

        ST_MULK: begin
          acc <= {mk_sum, acc[KW-1:1]};
          if (step == CNTW'(KW - 1)) begin
            step  <= '0;
            state <= ST_DIV;
          end else begin
            step <= step + 1'b1;
          end
        end

        ST_DIV: begin
          rem <= div_ge ? FRAME_W'(trial - {1'b0, divisor}) : trial[FRAME_W-1:0];
          acc <= {acc[PW-2:0], div_ge};
          if (step == CNTW'(PW - 1)) begin
            step  <= '0;
            state <= ST_GAIN;
          end else begin
            step <= step + 1'b1;
          end
        end

        ST_GAIN: begin
          ramp_gain <= gclamp;
          sacc      <= '0;
          step      <= '0;
          state     <= ST_MULS;
        end

        ST_MULS: begin
          sacc      <= {ms_sum, sacc[GW-1:1]};
          ramp_gain <= ramp_gain >> 1;
          if (step == CNTW'(GW - 1)) begin
            step  <= '0;
            state <= ST_ROUND;
          end else begin
            step <= step + 1'b1;
          end
        end

        ST_ROUND: begin
          rval  <= sneg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
          state <= ST_FIN;
        end

        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            sample_out  <= packed_out;
            buffer_last <= last_flag;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_ch && last_fr)
      |=> (frame_position == '0 && channel_position == '0))
    else $error("counters did not restart after the last item of the buffer");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < divisor))
    else $error("divider remainder out of range");

  a_gain_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULS && step == '0) |-> (ramp_gain <= UNITY))
    else $error("ramp gain above unity");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    channel_position <= CW'(MAX_CHANNELS - 1))
    else $error("channel position beyond channel limit");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_valid && !out_ready) |=> (state == ST_FIN))
    else $error("result overwrote an item not yet taken");
`endif

endmodule
